>>> hdl/ifs_pkg.sv
// Package for the IFS chaos-game plotter: field widths, request and
// register codes, screen limits and lens table geometry.
// No dependencies.
package ifs_pkg;

   // lens table
   localparam int NUM_LENSES   = 32;
   localparam int LENS_IDX_W   = $clog2(NUM_LENSES);

   // point arithmetic
   localparam int FRAC_BITS    = 10;
   localparam int SUBPIX_BITS  = 8;
   localparam int COEF_W       = 12;
   localparam int POINT_W      = 32;
   localparam int PROD_W       = COEF_W + POINT_W;
   localparam int ACC_W        = PROD_W + 2;

   // warm-up and screen
   localparam int WARMUP_STEPS = 10;
   localparam int WARMUP_W     = 4;
   localparam int DIM_W        = 13;
   localparam int PIX_W        = 12;
   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = DIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHLIGHT = 2'd2;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_STEP    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // one lens table entry
   typedef struct packed {
      logic signed [POINT_W-1:0] off_y;
      logic signed [POINT_W-1:0] off_x;
      logic signed [COEF_W-1:0]  coef_b;
      logic signed [COEF_W-1:0]  coef_a;
   } lens_type;

endpackage

>>> hdl/ifs_chaos_game_plotter_top.sv
// IFS chaos-game plotter, top level: lens table, shared multiplier,
// sequencer and result register. Depends on ifs_pkg.
//
// Keeps one point in 1/256-pixel fixed point and a table of 32 lenses.
// A load item writes one lens and a restart item puts the point at the
// screen center; neither stalls the request port. A step item applies its
// lens through a single shared 12x32 multiplier that forms the four
// products of the lens one after another into an accumulator. After
// warm-up, when a highlight lens is set, that lens goes through the same
// multiplier a second time. The first ten steps after reset or restart
// plot nothing; later steps give one pixel when the point lies on the
// screen. A finished pixel waits in the output register while the next
// item is taken. Lenses must be loaded before use; their content after
// reset is unknown.
module ifs_chaos_game_plotter_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [ifs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ifs_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [4:0]                        req_lens_index,
   input  logic signed [11:0]                req_coef_a,
   input  logic signed [11:0]                req_coef_b,
   input  logic signed [31:0]                req_offset_x,
   input  logic signed [31:0]                req_offset_y,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ifs_pkg::PIX_W-1:0]         rsp_pixel_x,
   output logic [ifs_pkg::PIX_W-1:0]         rsp_pixel_y
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAC,
      S_POST,
      S_CHECK
   } state_type;

   localparam int LW = ifs_pkg::LENS_IDX_W;
   localparam int PW = ifs_pkg::POINT_W;
   localparam int AW = ifs_pkg::ACC_W;
   localparam int FB = ifs_pkg::FRAC_BITS;
   localparam int SB = ifs_pkg::SUBPIX_BITS;
   localparam int DW = ifs_pkg::DIM_W;
   localparam int XW = ifs_pkg::DIM_W + ifs_pkg::SUBPIX_BITS;

   // registers
   state_type                          state_ff;
   logic [2:0]                         phase_ff;
   logic                               pass2_ff;
   logic [DW-1:0]                      width_ff;
   logic [DW-1:0]                      height_ff;
   logic [4:0]                         highlight_ff;
   logic signed [PW-1:0]               point_x_ff;
   logic signed [PW-1:0]               point_y_ff;
   logic [ifs_pkg::WARMUP_W-1:0]       warmup_ff;
   logic signed [PW-1:0]               work_x_ff;
   logic signed [PW-1:0]               work_y_ff;
   logic signed [AW-1:0]               acc_ff;
   logic signed [ifs_pkg::PROD_W-1:0]  prod_ff;
   logic                               rsp_valid_ff;
   logic [ifs_pkg::PIX_W-1:0]          pixel_x_ff;
   logic [ifs_pkg::PIX_W-1:0]          pixel_y_ff;
   ifs_pkg::lens_type                  lens_mem_ff [ifs_pkg::NUM_LENSES];
   ifs_pkg::lens_type                  lens_rd_ff;

   // combinational
   logic                               req_accept;
   logic                               mem_wr_en;
   logic                               mem_rd_en;
   logic [LW-1:0]                      mem_rd_addr;
   ifs_pkg::lens_type                  mem_wr_data;
   logic [DW-1:0]                      width_clamped;
   logic [DW-1:0]                      height_clamped;
   logic signed [ifs_pkg::COEF_W-1:0]  mul_coef;
   logic signed [PW-1:0]               mul_data;
   logic signed [ifs_pkg::PROD_W-1:0]  prod_in;
   logic signed [AW-1:0]               prod_ext;
   logic signed [AW-1:0]               acc_sum;
   logic [XW-1:0]                      bound_x;
   logic [XW-1:0]                      bound_y;
   logic                               on_screen;
   logic                               out_free;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = pixel_x_ff;
   assign rsp_pixel_y = pixel_y_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // screen size limited to the largest supported dimension
   assign width_clamped  = (width_ff  > ifs_pkg::MAX_DIM) ? ifs_pkg::MAX_DIM : width_ff;
   assign height_clamped = (height_ff > ifs_pkg::MAX_DIM) ? ifs_pkg::MAX_DIM : height_ff;
   assign bound_x = {width_clamped,  {SB{1'b0}}};
   assign bound_y = {height_clamped, {SB{1'b0}}};

   // bounds test on the finished point (negative values are off screen)
   assign on_screen = !work_x_ff[PW-1] && !work_y_ff[PW-1]
                   && (work_x_ff < PW'(bound_x)) && (work_y_ff < PW'(bound_y));

   // lens table port control
   assign mem_wr_en   = req_accept && (req_type == ifs_pkg::REQ_LOAD);
   assign mem_wr_data = '{off_y: req_offset_y, off_x: req_offset_x,
                          coef_b: req_coef_b, coef_a: req_coef_a};
   assign mem_rd_en   = (req_accept && (req_type == ifs_pkg::REQ_STEP))
                     || (state_ff == S_POST);
   assign mem_rd_addr = (state_ff == S_IDLE) ? req_lens_index[LW-1:0]
                                             : highlight_ff[LW-1:0];

   // shared multiplier: phase 0 a*x, 1 b*y, 2 b*x, 3 a*y
   always_comb begin
      mul_coef = ((phase_ff == 3'd0) || (phase_ff == 3'd3)) ? lens_rd_ff.coef_a
                                                            : lens_rd_ff.coef_b;
      mul_data = ((phase_ff == 3'd0) || (phase_ff == 3'd2)) ? work_x_ff : work_y_ff;
      prod_in  = mul_coef * mul_data;
   end

   assign prod_ext = AW'(prod_ff);
   assign acc_sum  = acc_ff + prod_ext;

   // lens table
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         lens_mem_ff[req_lens_index[LW-1:0]] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         lens_rd_ff <= lens_mem_ff[mem_rd_addr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 13'd640;
         height_ff    <= 13'd480;
         highlight_ff <= 5'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ifs_pkg::CSR_WIDTH:     width_ff     <= csr_write_data;
            ifs_pkg::CSR_HEIGHT:    height_ff    <= csr_write_data;
            ifs_pkg::CSR_HIGHLIGHT: highlight_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // sequencer, point state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 3'd0;
         pass2_ff     <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         warmup_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the pixel once taken, unless a new one replaces it now
         if (rsp_valid_ff && !rsp_stall && !((state_ff == S_CHECK) && on_screen)) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ff <= prod_in;
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  case (req_type)
                     ifs_pkg::REQ_STEP: begin
                        work_x_ff <= point_x_ff;
                        work_y_ff <= point_y_ff;
                        phase_ff  <= 3'd0;
                        pass2_ff  <= 1'b0;
                        state_ff  <= S_MAC;
                     end
                     ifs_pkg::REQ_RESTART: begin
                        point_x_ff <= PW'({width_clamped,  {(SB-1){1'b0}}});
                        point_y_ff <= PW'({height_clamped, {(SB-1){1'b0}}});
                        warmup_ff  <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_MAC: begin
               phase_ff <= (phase_ff == 3'd5) ? 3'd0 : phase_ff + 3'd1;
               case (phase_ff)
                  3'd0: acc_ff <= AW'(lens_rd_ff.off_x);
                  3'd1: acc_ff <= acc_sum;
                  3'd2: acc_ff <= acc_sum;
                  3'd3: begin
                     work_x_ff <= acc_ff[FB +: PW];
                     acc_ff    <= AW'(lens_rd_ff.off_y) - prod_ext;
                  end
                  3'd4: acc_ff <= acc_sum;
                  default: begin
                     work_y_ff <= acc_ff[FB +: PW];
                     state_ff  <= S_POST;
                  end
               endcase
            end
            S_POST: begin
               if (pass2_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  point_x_ff <= work_x_ff;
                  point_y_ff <= work_y_ff;
                  if (warmup_ff < ifs_pkg::WARMUP_W'(ifs_pkg::WARMUP_STEPS)) begin
                     warmup_ff <= warmup_ff + 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (highlight_ff != 5'd0) begin
                     // lens read issued this cycle by mem_rd_en
                     pass2_ff <= 1'b1;
                     state_ff <= S_MAC;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               if (out_free) begin
                  if (on_screen) begin
                     rsp_valid_ff <= 1'b1;
                     pixel_x_ff   <= work_x_ff[SB +: ifs_pkg::PIX_W];
                     pixel_y_ff   <= work_y_ff[SB +: ifs_pkg::PIX_W];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // a new pixel only comes from the bounds check
   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_CHECK))
      else $error("pixel raised outside bounds check");

   // warm-up counter saturates
   a_warmup_sat: assert property (@(posedge clock) disable iff (reset)
      warmup_ff <= ifs_pkg::WARMUP_W'(ifs_pkg::WARMUP_STEPS))
      else $error("warm-up counter beyond limit");

   // multiply-accumulate phase stays in range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (phase_ff <= 3'd5))
      else $error("MAC phase out of range");

   // a step item starts the multiply sequence at phase zero
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_type == ifs_pkg::REQ_STEP))
      |=> (state_ff == S_MAC) && (phase_ff == 3'd0))
      else $error("step item did not start lens evaluation");
`endif

endmodule
